>>> hw/rtl/wmcp_pkg.sv
// Package for the window majority colour picker.
// Holds the sizes, face codes, register indexes and the token that moves along the cell chain.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none

package wmcp_pkg;

    // Window capacity: one cell per pixel that a window may hold.
    localparam int MAX_WINDOW_PIXELS = 128;
    localparam int CNT_W             = $clog2(MAX_WINDOW_PIXELS + 1);

    localparam int CODE_W     = 24;
    localparam int CHAN_W     = 8;
    localparam int FACE_W     = 3;
    localparam int WCOUNT_W   = 8;
    localparam int NUM_FACES  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;
    localparam int M_FIELDS_W = FACE_W + CODE_W + WCOUNT_W;

    // Face codes of the result.
    localparam logic [FACE_W-1:0] FACE_TOP       = 3'd0;
    localparam logic [FACE_W-1:0] FACE_RIGHT     = 3'd1;
    localparam logic [FACE_W-1:0] FACE_FRONT     = 3'd2;
    localparam logic [FACE_W-1:0] FACE_BOTTOM    = 3'd3;
    localparam logic [FACE_W-1:0] FACE_LEFT      = 3'd4;
    localparam logic [FACE_W-1:0] FACE_BACK      = 3'd5;
    localparam logic [FACE_W-1:0] FACE_UNKNOWN   = 3'd6;
    localparam logic [FACE_W-1:0] FACE_UNCERTAIN = 3'd7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BACK   = 3'd5;

    // Reset values of the face colour registers.
    localparam logic [CODE_W-1:0] TOP_RESET    = 24'd8388479;
    localparam logic [CODE_W-1:0] RIGHT_RESET  = 24'd16744319;
    localparam logic [CODE_W-1:0] FRONT_RESET  = 24'd8355839;
    localparam logic [CODE_W-1:0] BOTTOM_RESET = 24'd8323199;
    localparam logic [CODE_W-1:0] LEFT_RESET   = 24'd32639;
    localparam logic [CODE_W-1:0] BACK_RESET   = 24'd8355584;

    // One pixel as it travels along the chain.
    typedef struct packed {
        logic              vld;   // token present
        logic              drop;  // pixel beyond capacity, not counted
        logic              last;  // closes the window
        logic              hit;   // a cell has already counted it
        logic [CODE_W-1:0] code;  // packed colour
        logic [CNT_W-1:0]  cnt;   // count of its colour after this pixel
        logic [CNT_W-1:0]  pix;   // pixels counted in the window so far
    } token_t;

endpackage

`default_nettype wire

>>> hw/rtl/wmcp_cell.sv
// One cell of the colour counting chain: holds one distinct colour and its count.
// Depends on wmcp_pkg for the token type and widths.
`default_nettype none

module wmcp_cell (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            advance,
    input  wire wmcp_pkg::token_t tok_in,
    output wmcp_pkg::token_t     tok_out
);

    logic                         valid_reg, valid_next;
    logic [wmcp_pkg::CODE_W-1:0]  code_reg, code_next;
    logic [wmcp_pkg::CNT_W-1:0]   count_reg, count_next;
    wmcp_pkg::token_t             tok_reg, tok_next;

    // Count the passing pixel if it matches this cell, or claim the cell if it is free.
    // The closing pixel empties the cell after its own update.
    always_comb begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        code_next  = code_reg;
        count_next = count_reg;
        if (tok_in.vld && !tok_in.drop && !tok_in.hit) begin
            if (valid_reg && (code_reg == tok_in.code)) begin
                count_next   = wmcp_pkg::CNT_W'(count_reg + 1'b1);
                tok_next.cnt = count_next;
                tok_next.hit = 1'b1;
            end else if (!valid_reg) begin
                valid_next   = 1'b1;
                code_next    = tok_in.code;
                count_next   = wmcp_pkg::CNT_W'(1);
                tok_next.cnt = count_next;
                tok_next.hit = 1'b1;
            end
        end
        if (tok_in.vld && tok_in.last) begin
            valid_next = 1'b0;
        end
    end

    // Cell state and the token handed to the next cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            tok_reg.vld <= 1'b0;
        end else if (advance) begin
            valid_reg <= valid_next;
            code_reg  <= code_next;
            count_reg <= count_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

>>> hw/rtl/wmcp_tally.sv
// Running winner at the end of the chain and the result output register.
// Depends on wmcp_pkg for the token type and widths.
`default_nettype none

module wmcp_tally (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         advance,
    input  wire wmcp_pkg::token_t             tok_in,
    input  wire logic                         m_tready,
    output logic                              res_valid,
    output logic [wmcp_pkg::CODE_W-1:0]       res_color,
    output logic [wmcp_pkg::CNT_W-1:0]        res_count,
    output logic [wmcp_pkg::CNT_W-1:0]        res_pix
);

    logic [wmcp_pkg::CODE_W-1:0] best_color_reg, best_color_next;
    logic [wmcp_pkg::CNT_W-1:0]  best_count_reg, best_count_next;
    logic                        res_valid_reg;
    logic [wmcp_pkg::CODE_W-1:0] res_color_reg;
    logic [wmcp_pkg::CNT_W-1:0]  res_count_reg;
    logic [wmcp_pkg::CNT_W-1:0]  res_pix_reg;

    // A higher count wins; an equal count wins with a smaller colour.
    always_comb begin
        best_color_next = best_color_reg;
        best_count_next = best_count_reg;
        if (tok_in.vld && !tok_in.drop) begin
            if ((tok_in.cnt > best_count_reg) ||
                ((tok_in.cnt == best_count_reg) && (tok_in.code < best_color_reg))) begin
                best_color_next = tok_in.code;
                best_count_next = tok_in.cnt;
            end
        end
    end

    // Winner registers and the result register; a closing pixel loads a result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_color_reg <= '0;
            best_count_reg <= '0;
            res_valid_reg  <= 1'b0;
        end else begin
            // A closing pixel fills the result register; otherwise a transfer empties it.
            if (advance && tok_in.vld && tok_in.last) begin
                res_valid_reg <= 1'b1;
            end else if (res_valid_reg && m_tready) begin
                res_valid_reg <= 1'b0;
            end
            if (advance) begin
                if (tok_in.vld && tok_in.last) begin
                    res_color_reg  <= best_color_next;
                    res_count_reg  <= best_count_next;
                    res_pix_reg    <= tok_in.pix;
                    best_color_reg <= '0;
                    best_count_reg <= '0;
                end else begin
                    best_color_reg <= best_color_next;
                    best_count_reg <= best_count_next;
                end
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_color = res_color_reg;
    assign res_count = res_count_reg;
    assign res_pix   = res_pix_reg;

endmodule

`default_nettype wire

>>> hw/rtl/window_majority_color_pick.sv
// Window majority colour picker. Pixels enter one per cycle and walk a chain of
// MAX_WINDOW_PIXELS cells (128), one cell per cycle; each cell holds one distinct colour
// and its count, so a pixel is counted as it passes. A result is registered once its
// closing pixel (tlast) has passed all the cells, and windows may follow each other
// without gaps, sustaining one pixel per cycle. The chain moves as one: while a result
// waits on m_tready the whole chain, and with it s_tready, holds. The closing pixel empties
// every cell as it passes, so no clearing pass is needed after reset or between windows.
// Depends on wmcp_pkg, wmcp_cell and wmcp_tally.
`default_nettype none

module window_majority_color_pick (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Pixel input
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [wmcp_pkg::S_TDATA_W-1:0]    s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  wire logic                              s_tlast,   // window_end
    // Result output
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [wmcp_pkg::M_TDATA_W-1:0]         m_tdata,   // face_code[2:0],
                                                              // winning_color[26:3],
                                                              // winning_count[34:27], zeros
    // Configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [wmcp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [wmcp_pkg::CODE_W-1:0]       cfg_wdata
);

    localparam int N = wmcp_pkg::MAX_WINDOW_PIXELS;

    logic [wmcp_pkg::CODE_W-1:0] face_reg [wmcp_pkg::NUM_FACES];
    logic [wmcp_pkg::CNT_W-1:0]  pixels_seen_reg, pixels_seen_next;
    logic                        advance;
    logic                        drop;
    logic [wmcp_pkg::CNT_W-1:0]  pix_after;
    wmcp_pkg::token_t            chain [N+1];

    logic                        res_valid;
    logic [wmcp_pkg::CODE_W-1:0] res_color;
    logic [wmcp_pkg::CNT_W-1:0]  res_count;
    logic [wmcp_pkg::CNT_W-1:0]  res_pix;
    logic [wmcp_pkg::FACE_W-1:0] face_code;
    logic [31:0]                 count_wide;

    // The chain moves whenever the result register is free or being emptied.
    assign advance  = !res_valid || m_tready;
    assign s_tready = advance;

    // Face colour registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_reg[0] <= wmcp_pkg::TOP_RESET;
            face_reg[1] <= wmcp_pkg::RIGHT_RESET;
            face_reg[2] <= wmcp_pkg::FRONT_RESET;
            face_reg[3] <= wmcp_pkg::BOTTOM_RESET;
            face_reg[4] <= wmcp_pkg::LEFT_RESET;
            face_reg[5] <= wmcp_pkg::BACK_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                wmcp_pkg::REG_TOP:    face_reg[0] <= cfg_wdata;
                wmcp_pkg::REG_RIGHT:  face_reg[1] <= cfg_wdata;
                wmcp_pkg::REG_FRONT:  face_reg[2] <= cfg_wdata;
                wmcp_pkg::REG_BOTTOM: face_reg[3] <= cfg_wdata;
                wmcp_pkg::REG_LEFT:   face_reg[4] <= cfg_wdata;
                wmcp_pkg::REG_BACK:   face_reg[5] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pixel count of the current window; pixels beyond capacity are marked as dropped.
    always_comb begin
        drop      = (pixels_seen_reg == wmcp_pkg::CNT_W'(N));
        pix_after = drop ? pixels_seen_reg : wmcp_pkg::CNT_W'(pixels_seen_reg + 1'b1);
        pixels_seen_next = s_tlast ? '0 : pix_after;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixels_seen_reg <= '0;
        end else if (s_tvalid && advance) begin
            pixels_seen_reg <= pixels_seen_next;
        end
    end

    // Token entering the first cell.
    always_comb begin
        chain[0].vld  = s_tvalid;
        chain[0].drop = drop;
        chain[0].last = s_tlast;
        chain[0].hit  = 1'b0;
        chain[0].code = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
        chain[0].cnt  = '0;
        chain[0].pix  = pix_after;
    end

    // The row of counting cells.
    for (genvar i = 0; i < N; i++) begin : g_cell
        wmcp_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    wmcp_tally u_tally (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .tok_in    (chain[N]),
        .m_tready  (m_tready),
        .res_valid (res_valid),
        .res_color (res_color),
        .res_count (res_count),
        .res_pix   (res_pix)
    );

    // Face decision from the held result; the user must change registers only while idle,
    // as the block has no guard. The first matching face in register order wins.
    always_comb begin
        if (res_count >= (res_pix >> 1)) begin
            face_code = wmcp_pkg::FACE_UNKNOWN;
            if (face_reg[5] == res_color) face_code = wmcp_pkg::FACE_BACK;
            if (face_reg[4] == res_color) face_code = wmcp_pkg::FACE_LEFT;
            if (face_reg[3] == res_color) face_code = wmcp_pkg::FACE_BOTTOM;
            if (face_reg[2] == res_color) face_code = wmcp_pkg::FACE_FRONT;
            if (face_reg[1] == res_color) face_code = wmcp_pkg::FACE_RIGHT;
            if (face_reg[0] == res_color) face_code = wmcp_pkg::FACE_TOP;
        end else begin
            face_code = wmcp_pkg::FACE_UNCERTAIN;
        end
    end

    // Output packing.
    assign count_wide = 32'(res_count);
    assign m_tvalid   = res_valid;
    assign m_tdata    = {{(wmcp_pkg::M_TDATA_W - wmcp_pkg::M_FIELDS_W){1'b0}},
                         count_wide[wmcp_pkg::WCOUNT_W-1:0], res_color, face_code};

endmodule

`default_nettype wire

>>> hw/rtl/wmcp_checker.sv
// Port-level checks for the window majority colour picker, bound to the top level.
// Depends on wmcp_pkg for port widths.
`default_nettype none

module wmcp_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tready,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [wmcp_pkg::M_TDATA_W-1:0]    m_tdata
);

    // A stalled result holds its value until it is transferred.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or vanished while stalled");

    // The input is stalled exactly when a result waits and is not taken.
    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the output stall");

    // Every window counts at least one pixel, so a winner always has a count.
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[34:27] != 8'd0))
        else $error("result with zero winning count");

    // No result is shown straight after reset.
    a_quiet_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present straight after reset");

endmodule

bind window_majority_color_pick wmcp_checker u_wmcp_checker (.*);

`default_nettype wire
